### rtl/fww_pkg.sv
`timescale 1ns / 1ps
package fww_pkg;

   localparam int SAMPLE_W = 16;
   localparam int INDEX_W  = 10;
   localparam int KIND_W   = 3;
   localparam int LEN_W    = 11;
   localparam int CSR_W    = 11;
   localparam int COEF_W   = 18;
   localparam int OUT_W    = 25;
   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 16;

   localparam logic [KIND_W-1:0] KIND_RECT     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TRIANGLE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_HANN     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_HAMMING  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_BLACKMAN = 3'd4;
   localparam logic [KIND_W-1:0] KIND_FLATTOP  = 3'd5;

   localparam logic CSR_WINDOW_KIND  = 1'b0;
   localparam logic CSR_FRAME_LENGTH = 1'b1;

   localparam logic [KIND_W-1:0] KIND_RESET = KIND_RECT;
   localparam logic [LEN_W-1:0]  LEN_RESET  = 11'd1024;

   localparam logic [30:0] Q30_ONE     = 31'd1073741824;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic signed [COEF_W-1:0] Q16_ONE  = 18'sd65536;
   localparam logic signed [COEF_W-1:0] COEF_MAX = 18'sd131071;
   localparam logic signed [COEF_W-1:0] COEF_MIN = -18'sd131072;
   localparam logic signed [OUT_W-1:0]  OUT_MAX  = 25'sd16776960;
   localparam logic signed [OUT_W-1:0]  OUT_MIN  = -25'sd8388608;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

   // (2k-1)(2k) for the nested cosine series
   function automatic logic [7:0] taylor_div(input logic [2:0] k);
      logic [7:0] d;
      case (k)
         3'd6:    d = 8'd132;
         3'd5:    d = 8'd90;
         3'd4:    d = 8'd56;
         3'd3:    d = 8'd30;
         3'd2:    d = 8'd12;
         default: d = 8'd2;
      endcase
      return d;
   endfunction

   // constant term of the window sum, in units of Q30 one
   function automatic logic [15:0] base_weight(input logic [KIND_W-1:0] kind);
      logic [15:0] w;
      case (kind)
         KIND_HANN:     w = 16'd1;
         KIND_HAMMING:  w = 16'd54;
         KIND_BLACKMAN: w = 16'd42;
         KIND_FLATTOP:  w = 16'd10000;
         default:       w = 16'd0;
      endcase
      return w;
   endfunction

   // weight of cos(2*pi*m*i/D)
   function automatic logic signed [15:0] term_weight(input logic [KIND_W-1:0] kind,
                                                      input logic [2:0] m);
      logic signed [15:0] w;
      w = '0;
      case (kind)
         KIND_HANN:     w = -16'sd1;
         KIND_HAMMING:  w = -16'sd46;
         KIND_BLACKMAN: w = (m == 3'd1) ? -16'sd50 : 16'sd8;
         KIND_FLATTOP: begin
            case (m)
               3'd1:    w = -16'sd19300;
               3'd2:    w = 16'sd12900;
               3'd3:    w = -16'sd3880;
               default: w = 16'sd322;
            endcase
         end
         default:       w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [2:0] term_count(input logic [KIND_W-1:0] kind);
      logic [2:0] n;
      case (kind)
         KIND_BLACKMAN: n = 3'd2;
         KIND_FLATTOP:  n = 3'd4;
         default:       n = 3'd1;
      endcase
      return n;
   endfunction

   // final scale divided by 2^14
   function automatic logic [15:0] round_div(input logic [KIND_W-1:0] kind);
      logic [15:0] d;
      case (kind)
         KIND_HANN:    d = 16'd2;
         KIND_FLATTOP: d = 16'd46340;
         default:      d = 16'd100;
      endcase
      return d;
   endfunction

endpackage

### rtl/fww_ram.sv
`timescale 1ns / 1ps
module fww_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fww_div.sv
`timescale 1ns / 1ps
module fww_div (
   input  logic                 clock,
   input  logic                 reset,
   input  fww_pkg::div_req_type req,
   output fww_pkg::div_rsp_type rsp
);

   import fww_pkg::*;

   localparam int RADIX_BITS = 4;
   localparam int STEPS = DIV_NUM_W / RADIX_BITS;
   localparam int CNT_W = $clog2(STEPS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] sh_ff, sh_in;

   always_comb begin
      logic [DIV_DEN_W:0]   r;
      logic [DIV_DEN_W-1:0] rem;
      logic [DIV_NUM_W-1:0] sh;
      rem     = rem_ff;
      sh      = sh_ff;
      r       = '0;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = req.den;
         rem     = '0;
         sh      = req.num;
      end else if (busy_ff) begin
         // restoring division, four quotient bits a cycle
         for (int j = 0; j < RADIX_BITS; j++) begin
            r  = {rem, sh[DIV_NUM_W-1]};
            sh = {sh[DIV_NUM_W-2:0], 1'b0};
            if (r >= {1'b0, den_ff}) begin
               rem   = DIV_DEN_W'(r - {1'b0, den_ff});
               sh[0] = 1'b1;
            end else begin
               rem = r[DIV_DEN_W-1:0];
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      rem_in = rem;
      sh_in  = sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      sh_ff  <= sh_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = sh_ff;

endmodule

### rtl/fft_window_weighting.sv
`timescale 1ns / 1ps
// Window weighting for an FFT front end: each transfer on req carries an unsigned sample and
// its index in the frame, and rsp returns the sample times the window coefficient with 8
// fraction bits, saturated, or zero with index_out_of_range set when the index is not below
// the frame length (capped at MAX_FRAME). Items stream at one per clock while rsp_stall is low
// and no rebuild runs, each going through registered table read, multiply and saturate; the
// coefficient memory has one read port for items and one write port for the table builder.
// After reset and after every csr write the table is rebuilt and req is stalled meanwhile:
// an iterative cosine unit built around a shared 4-bit-per-cycle divider computes the cosine
// windows' entries; triangular entries use the divider alone. A csr write restarts the rebuild.
module fft_window_weighting #(
   parameter int MAX_FRAME = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wr_en,
   input  logic                                    csr_index,
   input  logic [fww_pkg::CSR_W-1:0]               csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [fww_pkg::SAMPLE_W-1:0]            req_sample_value,
   input  logic [fww_pkg::INDEX_W-1:0]             req_sample_index,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [fww_pkg::OUT_W-1:0]        rsp_weighted_sample,
   output logic                                    rsp_index_out_of_range
);

   import fww_pkg::*;

   localparam int AW = $clog2(MAX_FRAME);

   typedef enum logic [15:0] {
      B_IDLE   = 16'b0000000000000001,
      B_ENTRY  = 16'b0000000000000010,
      B_TRIDIV = 16'b0000000000000100,
      B_CSTART = 16'b0000000000001000,
      B_CDIV   = 16'b0000000000010000,
      B_XMUL   = 16'b0000000000100000,
      B_X2     = 16'b0000000001000000,
      B_TMUL   = 16'b0000000010000000,
      B_TSTART = 16'b0000000100000000,
      B_TDIV   = 16'b0000001000000000,
      B_CFIN   = 16'b0000010000000000,
      B_CMUL   = 16'b0000100000000000,
      B_CADD   = 16'b0001000000000000,
      B_RSTART = 16'b0010000000000000,
      B_RDIV   = 16'b0100000000000000,
      B_WRITE  = 16'b1000000000000000
   } build_state_type;

   // configuration
   logic [KIND_W-1:0] kind_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  eff_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_RESET;
         len_ff  <= LEN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_KIND:  kind_ff <= csr_wdata[KIND_W-1:0];
            CSR_FRAME_LENGTH: len_ff  <= csr_wdata[LEN_W-1:0];
            default:          ;
         endcase
      end
   end

   assign eff_len = ({21'd0, len_ff} > 32'(MAX_FRAME)) ? LEN_W'(MAX_FRAME) : len_ff;

   // table builder
   build_state_type      bstate_ff, bstate_in;
   logic [LEN_W-1:0]     idx_ff, idx_in;
   logic [2:0]           m_ff, m_in;
   logic [2:0]           k_ff, k_in;
   logic [31:0]          t_ff, t_in;
   logic [30:0]          x_ff, x_in;
   logic [31:0]          x2_ff, x2_in;
   logic signed [31:0]   term_ff, term_in;
   logic signed [31:0]   c_ff, c_in;
   logic signed [63:0]   prod_ff, prod_in;
   logic signed [47:0]   acc_ff, acc_in;
   logic signed [COEF_W-1:0] coef_ff, coef_in;
   logic                 neg_ff, neg_in;
   div_req_type          div_req;
   div_rsp_type          div_rsp;
   logic                 ram_we;

   logic                 cos_kind;
   logic [LEN_W:0]       dsp;
   logic [LEN_W-1:0]     tri_k;
   logic [30:0]          u;
   logic [61:0]          px;
   logic [61:0]          pxx;
   logic signed [63:0]   mul_t;
   logic signed [47:0]   mul_c;
   logic [63:0]          pmag;
   logic [47:0]          amag;
   logic [47:0]          rsum;
   logic [13:0]          mi;
   logic signed [34:0]   qs;
   logic signed [34:0]   tnew;
   logic signed [31:0]   tclamp;

   assign cos_kind = kind_ff inside {KIND_HANN, KIND_HAMMING, KIND_BLACKMAN, KIND_FLATTOP};
   assign dsp   = (kind_ff == KIND_HANN) ? ({1'b0, eff_len} + 1'b1) : ({1'b0, eff_len} - 1'b1);
   assign tri_k = (idx_ff < (eff_len - 1'b1 - idx_ff)) ? idx_ff : (eff_len - 1'b1 - idx_ff);
   assign u     = t_ff[30] ? (Q30_ONE - {1'b0, t_ff[29:0]}) : {1'b0, t_ff[29:0]};
   assign px    = 62'(u) * 62'(HALF_PI_Q30);
   assign pxx   = 62'(x_ff) * 62'(x_ff);
   assign mul_t = $signed({1'b0, x2_ff}) * term_ff;
   assign mul_c = term_weight(kind_ff, m_ff) * c_ff;
   assign pmag  = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
   assign amag  = acc_ff[47] ? 48'(-acc_ff) : 48'(acc_ff);
   assign rsum  = amag + (48'(round_div(kind_ff)) << 13);
   assign mi    = 14'(m_ff) * 14'(idx_ff);
   assign qs    = neg_ff ? -$signed({1'b0, div_rsp.quo[33:0]})
                         : $signed({1'b0, div_rsp.quo[33:0]});
   assign tnew  = $signed({4'd0, Q30_ONE}) - qs;
   assign tclamp = (term_ff > $signed({1'b0, Q30_ONE})) ? $signed({1'b0, Q30_ONE}) :
                   (term_ff < -$signed({1'b0, Q30_ONE})) ? -$signed({1'b0, Q30_ONE}) :
                   term_ff;

   always_comb begin
      bstate_in = bstate_ff;
      idx_in  = idx_ff;
      m_in    = m_ff;
      k_in    = k_ff;
      t_in    = t_ff;
      x_in    = x_ff;
      x2_in   = x2_ff;
      term_in = term_ff;
      c_in    = c_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      coef_in = coef_ff;
      neg_in  = neg_ff;
      div_req = '0;
      ram_we  = 1'b0;
      case (bstate_ff)
         B_IDLE: ;
         B_ENTRY: begin
            if (idx_ff >= eff_len) begin
               bstate_in = B_IDLE;
            end else if (eff_len < 11'd2 || !(cos_kind || kind_ff == KIND_TRIANGLE)) begin
               coef_in   = Q16_ONE;
               bstate_in = B_WRITE;
            end else if (kind_ff == KIND_TRIANGLE) begin
               div_req.start = 1'b1;
               div_req.num   = 48'({tri_k, 17'd0}) + 48'(eff_len >> 1);
               div_req.den   = 16'(eff_len);
               bstate_in     = B_TRIDIV;
            end else begin
               acc_in    = $signed(48'(base_weight(kind_ff)) << 30);
               m_in      = 3'd1;
               bstate_in = B_CSTART;
            end
         end
         B_TRIDIV: begin
            if (div_rsp.done) begin
               coef_in   = $signed(div_rsp.quo[COEF_W-1:0]);
               bstate_in = B_WRITE;
            end
         end
         B_CSTART: begin
            div_req.start = 1'b1;
            div_req.num   = 48'({mi, 32'd0});
            div_req.den   = 16'(dsp);
            bstate_in     = B_CDIV;
         end
         B_CDIV: begin
            if (div_rsp.done) begin
               t_in      = div_rsp.quo[31:0];
               bstate_in = B_XMUL;
            end
         end
         B_XMUL: begin
            x_in      = px[60:30];
            bstate_in = B_X2;
         end
         B_X2: begin
            x2_in     = pxx[61:30];
            term_in   = $signed({1'b0, Q30_ONE});
            k_in      = 3'd6;
            bstate_in = B_TMUL;
         end
         B_TMUL: begin
            prod_in   = mul_t;
            bstate_in = B_TSTART;
         end
         B_TSTART: begin
            // truncation toward zero: divide the magnitude, restore the sign after
            neg_in        = prod_ff[63];
            div_req.start = 1'b1;
            div_req.num   = 48'(pmag[63:30]);
            div_req.den   = 16'(taylor_div(k_ff));
            bstate_in     = B_TDIV;
         end
         B_TDIV: begin
            if (div_rsp.done) begin
               term_in = 32'(tnew);
               if (k_ff == 3'd1) begin
                  bstate_in = B_CFIN;
               end else begin
                  k_in      = k_ff - 1'b1;
                  bstate_in = B_TMUL;
               end
            end
         end
         B_CFIN: begin
            // second and third quadrant flip the sign
            c_in      = (t_ff[31] ^ t_ff[30]) ? -tclamp : tclamp;
            bstate_in = B_CMUL;
         end
         B_CMUL: begin
            prod_in   = 64'(mul_c);
            bstate_in = B_CADD;
         end
         B_CADD: begin
            acc_in = acc_ff + $signed(prod_ff[47:0]);
            if (m_ff == term_count(kind_ff)) begin
               bstate_in = B_RSTART;
            end else begin
               m_in      = m_ff + 1'b1;
               bstate_in = B_CSTART;
            end
         end
         B_RSTART: begin
            neg_in        = acc_ff[47];
            div_req.start = 1'b1;
            div_req.num   = 48'(rsum[47:14]);
            div_req.den   = round_div(kind_ff);
            bstate_in     = B_RDIV;
         end
         B_RDIV: begin
            if (div_rsp.done) begin
               if (qs > 35'(COEF_MAX)) begin
                  coef_in = COEF_MAX;
               end else if (qs < 35'(COEF_MIN)) begin
                  coef_in = COEF_MIN;
               end else begin
                  coef_in = COEF_W'(qs);
               end
               bstate_in = B_WRITE;
            end
         end
         B_WRITE: begin
            ram_we    = 1'b1;
            idx_in    = idx_ff + 1'b1;
            bstate_in = B_ENTRY;
         end
         default: bstate_in = B_IDLE;
      endcase
      if (csr_wr_en) begin
         bstate_in = B_ENTRY;
         idx_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff <= B_ENTRY;
         idx_ff    <= '0;
      end else begin
         bstate_ff <= bstate_in;
         idx_ff    <= idx_in;
      end
      m_ff    <= m_in;
      k_ff    <= k_in;
      t_ff    <= t_in;
      x_ff    <= x_in;
      x2_ff   <= x2_in;
      term_ff <= term_in;
      c_ff    <= c_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      coef_ff <= coef_in;
      neg_ff  <= neg_in;
   end

   fww_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // item pipeline: table read, multiply, scale and saturate
   logic                     en1, en2, en3;
   logic                     accept;
   logic                     v1_ff, v2_ff, v3_ff;
   logic [SAMPLE_W-1:0]      s1_ff;
   logic                     oor1_ff, oor2_ff, oor3_ff;
   logic signed [34:0]       p2_ff, p2_in;
   logic signed [OUT_W-1:0]  w3_ff, w3_in;
   logic [COEF_W-1:0]        rd_coef;
   logic signed [26:0]       sh;

   assign en3 = !v3_ff || !rsp_stall;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1 || (bstate_ff != B_IDLE) || csr_wr_en;
   assign accept = req_valid && !req_stall;

   fww_ram #(
      .WIDTH (COEF_W),
      .DEPTH (MAX_FRAME)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(idx_ff)),
      .wr_data (coef_ff),
      .rd_en   (en1),
      .rd_addr (AW'(req_sample_index)),
      .rd_data (rd_coef)
   );

   assign p2_in = $signed({1'b0, s1_ff}) * $signed(rd_coef);
   assign sh    = p2_ff[34:8];
   always_comb begin
      if (oor2_ff) begin
         w3_in = '0;
      end else if (sh > 27'(OUT_MAX)) begin
         w3_in = OUT_MAX;
      end else if (sh < 27'(OUT_MIN)) begin
         w3_in = OUT_MIN;
      end else begin
         w3_in = OUT_W'(sh);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= accept;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
      if (en1) begin
         s1_ff   <= req_sample_value;
         oor1_ff <= ({1'b0, req_sample_index} >= eff_len);
      end
      if (en2) begin
         p2_ff   <= p2_in;
         oor2_ff <= oor1_ff;
      end
      if (en3) begin
         w3_ff   <= w3_in;
         oor3_ff <= oor2_ff;
      end
   end

   assign rsp_valid              = v3_ff;
   assign rsp_weighted_sample    = w3_ff;
   assign rsp_index_out_of_range = oor3_ff;

endmodule

### bench/fft_window_weighting_test.sv
`timescale 1ns / 1ps
module fft_window_weighting_test;
   import fww_pkg::*;

   localparam longint ONE_Q30     = 64'd1073741824;
   localparam longint HALF_PI_Q   = 64'd1686629713;
   localparam int     STALL_LIMIT = 400000;
   localparam int     ROWS        = 21;
   localparam int     PER_PHASE   = 40;

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [LEN_W-1:0]    len;
      logic [SAMPLE_W-1:0] sample;
      logic [INDEX_W-1:0]  idx;
      bit                  typed;
      int                  w;
      bit                  oor;
   } vector_row_type;

   typedef struct {
      logic signed [OUT_W-1:0] w;
      logic                    oor;
   } weighted_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic csr_index = CSR_WINDOW_KIND;
   logic [CSR_W-1:0] csr_wdata = '0;
   logic req_valid = 0;
   logic req_stall;
   logic [SAMPLE_W-1:0] req_sample_value = '0;
   logic [INDEX_W-1:0] req_sample_index = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [OUT_W-1:0] rsp_weighted_sample;
   logic rsp_index_out_of_range;

   weighted_type pending_weights[$];
   int failures = 0;
   int idle_cycles = 0;
   logic [KIND_W-1:0] cur_kind = KIND_RESET;
   logic [LEN_W-1:0] cur_len = LEN_RESET;
   int burst_left = 0;
   bit hold_go = 0;
   bit hold_active = 0;
   int stall_mode = 0;
   int stall_phase = 0;

   fft_window_weighting DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_sample_value(req_sample_value), .req_sample_index(req_sample_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_weighted_sample(rsp_weighted_sample),
      .rsp_index_out_of_range(rsp_index_out_of_range)
   );

   always #10 clock = ~clock;

   // cosine of u quarter turns, u and result in Q30
   function automatic longint quarter_cos(longint unsigned u);
      longint unsigned x;
      longint x2, term;
      x = (u * HALF_PI_Q) >> 30;
      x2 = longint'((x * x) >> 30);
      term = ONE_Q30;
      for (int k = 6; k >= 1; k--)
         term = ONE_Q30 - ((x2 * term) / ONE_Q30) / longint'((2 * k - 1) * (2 * k));
      if (term > ONE_Q30) term = ONE_Q30;
      if (term < -ONE_Q30) term = -ONE_Q30;
      return term;
   endfunction

   function automatic longint turn_cos(int unsigned m, int unsigned i, int unsigned d);
      int unsigned r;
      longint unsigned t, u;
      int unsigned q;
      longint c;
      r = (m * i) % d;
      t = (longint'(r) << 32) / d;
      q = int'(t >> 30) & 3;
      u = t & 64'h3FFF_FFFF;
      if (q[0]) u = (64'd1 << 30) - u;
      c = quarter_cos(u);
      if (q == 1 || q == 2) c = -c;
      return c;
   endfunction

   function automatic longint round_half_away(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic longint window_q16(logic [KIND_W-1:0] kind, int unsigned i,
                                         int unsigned len);
      int unsigned d, k;
      longint v;
      d = len - 1;
      if (len < 2) return 65536;
      case (kind)
         KIND_TRIANGLE: begin
            k = (i < len - 1 - i) ? i : len - 1 - i;
            v = round_half_away(longint'(k) * 2 * 65536, len);
         end
         KIND_HANN:
            v = round_half_away(ONE_Q30 - turn_cos(1, i, len + 1), 2 * 16384);
         KIND_HAMMING:
            v = round_half_away(54 * ONE_Q30 - 46 * turn_cos(1, i, d), 100 * 16384);
         KIND_BLACKMAN:
            v = round_half_away(42 * ONE_Q30 - 50 * turn_cos(1, i, d)
                                + 8 * turn_cos(2, i, d), 100 * 16384);
         KIND_FLATTOP:
            v = round_half_away(10000 * ONE_Q30 - 19300 * turn_cos(1, i, d)
                                + 12900 * turn_cos(2, i, d) - 3880 * turn_cos(3, i, d)
                                + 322 * turn_cos(4, i, d), 46340 * 16384);
         default: v = 65536;
      endcase
      if (v > 131071) v = 131071;
      if (v < -131072) v = -131072;
      return v;
   endfunction

   function automatic int unsigned frame_span();
      return (cur_len > 1024) ? 1024 : cur_len;
   endfunction

   function automatic weighted_type weigh_sample(logic [SAMPLE_W-1:0] s,
                                                 logic [INDEX_W-1:0] idx);
      weighted_type r;
      longint p;
      r.w = '0;
      r.oor = 1'b1;
      if (idx < frame_span()) begin
         p = longint'(s) * window_q16(cur_kind, idx, frame_span());
         p = p >>> 8;
         if (p > 16776960) p = 16776960;
         if (p < -8388608) p = -8388608;
         r.w = OUT_W'(p);
         r.oor = 1'b0;
      end
      return r;
   endfunction

   // response side: pattern stall plus the long hold-off
   always @(posedge clock) begin
      if (stall_phase == 0) stall_mode <= $urandom_range(0, 3);
      stall_phase <= (stall_phase + 1) % 64;
      case (stall_mode)
         0: rsp_stall <= hold_active;
         1: rsp_stall <= hold_active | ($urandom_range(0, 99) < 30);
         2: rsp_stall <= hold_active | stall_phase[0];
         default: rsp_stall <= hold_active | ($urandom_range(0, 99) < 70);
      endcase
   end

   initial begin
      wait (hold_go);
      hold_active = 1;
      repeat (300) @(posedge clock);
      hold_active = 0;
   end

   always @(posedge clock) begin
      weighted_type e;
      if (rsp_valid && !rsp_stall) begin
         if (pending_weights.size() == 0) begin
            $error("unexpected transfer on rsp");
            failures++;
         end else begin
            e = pending_weights.pop_front();
            if (rsp_weighted_sample !== e.w) begin
               $error("weighted_sample expected %0d got %0d", e.w, rsp_weighted_sample);
               failures++;
            end
            if (rsp_index_out_of_range !== e.oor) begin
               $error("index_out_of_range expected %0d got %0d", e.oor,
                      rsp_index_out_of_range);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic drain();
      while (pending_weights.size() != 0) @(posedge clock);
   endtask

   task automatic configure(logic [KIND_W-1:0] kind, logic [LEN_W-1:0] len);
      drain();
      repeat (8) @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= CSR_WINDOW_KIND;
      csr_wdata <= {8'($urandom), kind};
      @(posedge clock);
      csr_index <= CSR_FRAME_LENGTH;
      csr_wdata <= len;
      @(posedge clock);
      csr_wr_en <= 0;
      cur_kind = kind;
      cur_len = len;
   endtask

   // one transfer on req, with bursts and gaps on the sender side
   task automatic offer(logic [SAMPLE_W-1:0] s, logic [INDEX_W-1:0] idx, bit typed,
                        weighted_type typed_result);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1;
      req_sample_value <= s;
      req_sample_index <= idx;
      do @(posedge clock); while (req_stall);
      pending_weights.push_back(typed ? typed_result : weigh_sample(s, idx));
   endtask

   task automatic random_item();
      logic [SAMPLE_W-1:0] s;
      logic [INDEX_W-1:0] idx;
      weighted_type none;
      none = '{w: '0, oor: 0};
      case ($urandom_range(0, 19))
         0, 1:    s = 16'hFFFF;
         2:       s = '0;
         default: s = SAMPLE_W'($urandom);
      endcase
      if ($urandom_range(0, 99) < 85 && frame_span() > 0)
         idx = INDEX_W'($urandom_range(0, frame_span() - 1));
      else
         idx = INDEX_W'($urandom_range(0, 1023));
      offer(s, idx, 0, none);
   endtask

   initial begin
      vector_row_type rows[ROWS];
      logic [KIND_W-1:0] phase_kind[15];
      logic [LEN_W-1:0] phase_len[15];
      weighted_type t;
      rows = '{
         '{KIND_RECT, 1024, 0, 0, 1, 0, 0},
         '{KIND_RECT, 1024, 65535, 1023, 1, 16776960, 0},
         '{KIND_RECT, 1024, 1, 0, 1, 256, 0},
         '{KIND_RECT, 1024, 43690, 512, 0, 0, 0},
         '{KIND_RECT, 0, 1234, 0, 1, 0, 1},
         '{KIND_RECT, 0, 65535, 1023, 1, 0, 1},
         '{3'd6, 1, 100, 0, 1, 25600, 0},
         '{3'd6, 1, 100, 1, 1, 0, 1},
         '{3'd7, 2047, 65535, 1023, 1, 16776960, 0},
         '{KIND_TRIANGLE, 7, 65535, 0, 1, 0, 0},
         '{KIND_TRIANGLE, 7, 65535, 3, 0, 0, 0},
         '{KIND_TRIANGLE, 7, 1, 7, 1, 0, 1},
         '{KIND_HANN, 16, 65535, 0, 1, 0, 0},
         '{KIND_HANN, 16, 65535, 8, 0, 0, 0},
         '{KIND_HAMMING, 2, 65535, 0, 0, 0, 0},
         '{KIND_HAMMING, 2, 65535, 1, 0, 0, 0},
         '{KIND_BLACKMAN, 33, 65535, 16, 0, 0, 0},
         '{KIND_BLACKMAN, 33, 65535, 32, 0, 0, 0},
         '{KIND_FLATTOP, 20, 65535, 0, 0, 0, 0},
         '{KIND_FLATTOP, 20, 65535, 10, 0, 0, 0},
         '{KIND_FLATTOP, 20, 30000, 5, 0, 0, 0}
      };
      phase_kind = '{KIND_TRIANGLE, KIND_HANN, KIND_RECT, KIND_HAMMING, KIND_BLACKMAN,
                     KIND_FLATTOP, KIND_FLATTOP, KIND_TRIANGLE, KIND_HANN, KIND_TRIANGLE,
                     3'd6, 0, 0, 0, 0};
      phase_len = '{1024, 1024, 2047, 100, 64, 64, 2, 2, 3, 8, 5, 0, 0, 0, 0};
      for (int p = 11; p < 15; p++) begin
         phase_kind[p] = KIND_W'($urandom_range(0, 7));
         phase_len[p] = LEN_W'($urandom_range(2, 40));
      end

      repeat (10) @(posedge clock);
      reset <= 0;

      foreach (rows[r]) begin
         if (rows[r].kind != cur_kind || rows[r].len != cur_len) begin
            req_valid <= 0;
            configure(rows[r].kind, rows[r].len);
         end
         t.w = OUT_W'(rows[r].w);
         t.oor = rows[r].oor;
         offer(rows[r].sample, rows[r].idx, rows[r].typed, t);
      end

      for (int p = 0; p < 15; p++) begin
         req_valid <= 0;
         configure(phase_kind[p], phase_len[p]);
         for (int n = 0; n < PER_PHASE; n++) begin
            if (p == 3 && n == 5) hold_go = 1;
            if (p == 4 && n == 20) begin
               // sender waits for everything outstanding
               req_valid <= 0;
               drain();
               @(posedge clock);
            end
            random_item();
         end
      end
      req_valid <= 0;

      drain();
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
